@@ hw/rtl/ptts_pkg.sv @@
`default_nettype none
package ptts_pkg;

   localparam int MAX_TASKS = 8;
   localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int SCAN_W    = $clog2(MAX_TASKS + 1);

   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_CREATE  = 3'd1;
   localparam logic [2:0] MODE_SUSPEND = 3'd2;
   localparam logic [2:0] MODE_RESUME  = 3'd3;
   localparam logic [2:0] MODE_DELETE  = 3'd4;

   localparam logic [1:0] KIND_OK   = 2'd0;
   localparam logic [1:0] KIND_ERR  = 2'd1;
   localparam logic [1:0] KIND_FIRE = 2'd2;
   localparam logic [1:0] KIND_IDLE = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  task_index;
      logic [15:0] period;
      logic [7:0]  initial_delay;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] fired_task;
      logic       last;
   } rsp_type;

endpackage
`default_nettype wire

@@ hw/rtl/periodic_task_tick_scheduler_top.sv @@
// Table operations (create, suspend, resume, delete): result in the cycle after accept, busy stays
// low, so a new transaction can be taken every cycle.
// Tick: busy while the scan runs; one task slot is read from the slot memory per cycle and, if valid,
// written back in the following cycle. A fire result is held until the next slot fires or the scan
// ends; the last result of a tick is shown in the cycle busy falls. No receiver stall exists.
// Synchronous reset empties the table (valid and suspended marks cleared); memory is not cleared.
`default_nettype none
module periodic_task_tick_scheduler_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ptts_pkg::req_type req_data,
   output logic                   rsp_valid,
   output ptts_pkg::rsp_type      rsp_data
);
   import ptts_pkg::*;

   typedef enum logic {ST_IDLE, ST_TICK} state_type;

   state_type             state_ff, state_in;
   logic [SCAN_W-1:0]     scan_ff, scan_in;
   logic                  s1_active_ff, s1_active_in;
   logic [IDX_W-1:0]      s1_idx_ff, s1_idx_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [MAX_TASKS-1:0]  slot_valid_ff, slot_valid_in;
   logic [MAX_TASKS-1:0]  suspended_ff, suspended_in;

   // word: {reload_period, countdown}
   logic [31:0]           mem [MAX_TASKS];
   logic [31:0]           rd_data_ff;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wa;
   logic [31:0]           mem_wd;
   logic                  rd_en;

   logic                  accept;
   logic                  in_range;
   logic [IDX_W-1:0]      req_idx;
   logic [15:0]           cd_dec;
   logic [15:0]           reload;
   logic                  fire;

   assign accept   = start && !busy;
   assign in_range = req_data.task_index < 8'(MAX_TASKS);
   assign req_idx  = req_data.task_index[IDX_W-1:0];
   assign cd_dec   = rd_data_ff[15:0] - 16'd1;
   assign reload   = rd_data_ff[31:16];
   assign fire     = (cd_dec == 16'd0) && !suspended_ff[s1_idx_ff];
   assign rd_en    = (state_ff == ST_TICK) && (scan_ff < SCAN_W'(MAX_TASKS));

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      s1_active_in  = 1'b0;
      s1_idx_in     = scan_ff[IDX_W-1:0];
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      slot_valid_in = slot_valid_ff;
      suspended_in  = suspended_ff;
      mem_we        = 1'b0;
      mem_wa        = req_idx;
      mem_wd        = {req_data.period, req_data.period + {8'd0, req_data.initial_delay}};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{kind: KIND_OK, fired_task: 6'd0, last: 1'b1};
               if (req_data.mode == MODE_TICK) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_TICK;
                  scan_in      = '0;
                  pend_in      = 1'b0;
               end else if (req_data.mode > MODE_DELETE || !in_range) begin
                  rsp_in.kind = KIND_ERR;
               end else begin
                  case (req_data.mode)
                     MODE_CREATE: begin
                        if (req_data.period == 16'd0) begin
                           rsp_in.kind = KIND_ERR;
                        end else begin
                           mem_we                 = 1'b1;
                           suspended_in[req_idx]  = 1'b0;
                           slot_valid_in[req_idx] = 1'b1;
                        end
                     end
                     MODE_SUSPEND: suspended_in[req_idx] = 1'b1;
                     MODE_RESUME:  suspended_in[req_idx] = 1'b0;
                     default:      slot_valid_in[req_idx] = 1'b0;
                  endcase
               end
            end
         end
         ST_TICK: begin
            if (rd_en) begin
               s1_active_in = 1'b1;
               scan_in      = scan_ff + SCAN_W'(1);
            end
            if (s1_active_ff && slot_valid_ff[s1_idx_ff]) begin
               mem_we = 1'b1;
               mem_wa = s1_idx_ff;
               mem_wd = {reload, fire ? reload : cd_dec};
               if (fire) begin
                  // hold each fire until we know whether another follows
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{kind: KIND_FIRE, fired_task: 6'(pend_idx_ff), last: 1'b0};
                  end
                  pend_in     = 1'b1;
                  pend_idx_in = s1_idx_ff;
               end
            end
            if (!rd_en && !s1_active_ff) begin
               rsp_valid_in = 1'b1;
               if (pend_ff) begin
                  rsp_in = '{kind: KIND_FIRE, fired_task: 6'(pend_idx_ff), last: 1'b1};
               end else begin
                  rsp_in = '{kind: KIND_IDLE, fired_task: 6'd0, last: 1'b1};
               end
               pend_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_ff       <= '0;
         s1_active_ff  <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
         suspended_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         s1_active_ff  <= s1_active_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         slot_valid_ff <= slot_valid_in;
         suspended_ff  <= suspended_in;
      end
      s1_idx_ff   <= s1_idx_in;
      pend_idx_ff <= pend_idx_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[scan_ff[IDX_W-1:0]];
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fire_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_FIRE |-> rsp_data.fired_task < 6'(MAX_TASKS))
      else $error("fired task index out of range");

   a_tick_ends_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp_data.last)
      else $error("tick ended without a final result");

   a_tick_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.mode == MODE_TICK |=> busy && !rsp_valid)
      else $error("tick transaction did not start a scan");

   a_op_single_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.mode != MODE_TICK |=>
         rsp_valid && rsp_data.last && (rsp_data.kind == KIND_OK || rsp_data.kind == KIND_ERR))
      else $error("table operation gave a wrong result");

   a_idle_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_IDLE |-> rsp_data.last && !busy)
      else $error("idle tick result not final");

endmodule
`default_nettype wire

@@ bench/periodic_task_tick_scheduler_top_tb.sv @@
`default_nettype none
module periodic_task_tick_scheduler_top_tb;
   import ptts_pkg::*;

   localparam int         STALL_LIMIT  = 2000;
   localparam int         SETTLE_TICKS = MAX_TASKS + 4;
   localparam logic [2:0] MODE_UNUSED  = 3'd7;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp_data;

   // scheduler shadow state
   logic [15:0] slot_count  [MAX_TASKS];
   logic [15:0] slot_reload [MAX_TASKS];
   logic        slot_hold   [MAX_TASKS];
   logic        slot_live   [MAX_TASKS];

   rsp_type due_events[$];
   int      mismatch_count  = 0;
   int      quiet_cycles    = 0;
   int      sender_idle_pct = 0;

   periodic_task_tick_scheduler_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic req_type make_op(input logic [2:0] mode, input int idx,
                                       input int per, input int dly);
      req_type r;
      r.mode          = mode;
      r.task_index    = 8'(idx);
      r.period        = 16'(per);
      r.initial_delay = 8'(dly);
      return r;
   endfunction

   task automatic push_event(input logic [1:0] kind, input int slot, input logic last);
      rsp_type ev;
      ev.kind       = kind;
      ev.fired_task = 6'(slot);
      ev.last       = last;
      due_events.push_back(ev);
   endtask

   // advance the shadow table by one transaction and queue what it should emit
   task automatic apply_sched_op(input req_type r);
      int                   hits[$];
      int                   i;
      logic [IDX_W-1:0]     slot;
      slot = r.task_index[IDX_W-1:0];
      if (r.mode == MODE_TICK) begin
         for (i = 0; i < MAX_TASKS; i++) begin
            if (slot_live[i]) begin
               slot_count[i] = slot_count[i] - 16'd1;
               if (slot_count[i] == 16'd0 && !slot_hold[i]) begin
                  slot_count[i] = slot_reload[i];
                  hits.push_back(i);
               end
            end
         end
         if (hits.size() == 0)
            push_event(KIND_IDLE, 0, 1'b1);
         for (i = 0; i < hits.size(); i++)
            push_event(KIND_FIRE, hits[i], i == hits.size() - 1);
      end else if (r.mode > MODE_DELETE || r.task_index >= MAX_TASKS) begin
         push_event(KIND_ERR, 0, 1'b1);
      end else if (r.mode == MODE_CREATE && r.period == 16'd0) begin
         push_event(KIND_ERR, 0, 1'b1);
      end else begin
         case (r.mode)
            MODE_CREATE: begin
               slot_reload[slot] = r.period;
               slot_count[slot]  = r.period + {8'd0, r.initial_delay};
               slot_hold[slot]   = 1'b0;
               slot_live[slot]   = 1'b1;
            end
            MODE_SUSPEND: slot_hold[slot] = 1'b1;
            MODE_RESUME:  slot_hold[slot] = 1'b0;
            default:      slot_live[slot] = 1'b0;
         endcase
         push_event(KIND_OK, 0, 1'b1);
      end
   endtask

   // check first, then predict: a result never belongs to the transaction taken at the same edge
   always @(posedge clock) begin
      rsp_type exp_ev;
      if (!reset) begin
         if (rsp_valid) begin
            if (due_events.size() == 0) begin
               $display("%0t: unexpected result kind=%0d task=%0d last=%0d", $time,
                        rsp_data.kind, rsp_data.fired_task, rsp_data.last);
               mismatch_count++;
            end else begin
               exp_ev = due_events.pop_front();
               if (rsp_data.kind !== exp_ev.kind || rsp_data.fired_task !== exp_ev.fired_task ||
                   rsp_data.last !== exp_ev.last) begin
                  $display({"%0t: mismatch exp kind=%0d task=%0d last=%0d, ",
                            "got kind=%0d task=%0d last=%0d"},
                           $time, exp_ev.kind, exp_ev.fired_task, exp_ev.last,
                           rsp_data.kind, rsp_data.fired_task, rsp_data.last);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy)
            apply_sched_op(req);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, due_events.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_req(input req_type item);
      start <= 1'b1;
      req   <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (due_events.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic test_table_errors();
      send_req(make_op(MODE_TICK, 0, 0, 0));              // empty table
      send_req(make_op(MODE_UNUSED, 0, 1, 0));
      send_req(make_op(MODE_CREATE, MAX_TASKS, 1, 0));
      send_req(make_op(MODE_CREATE, 255, 16'hFFFF, 255));
      send_req(make_op(MODE_CREATE, 0, 0, 0));            // zero period
      send_req(make_op(MODE_SUSPEND, 255, 0, 0));
      send_req(make_op(MODE_DELETE, MAX_TASKS, 0, 0));
      send_req(make_op(MODE_SUSPEND, 3, 0, 0));           // empty slot, mark still written
      send_req(make_op(MODE_CREATE, MAX_TASKS - 1, 16'hFFFF, 255)); // countdown wraps
      send_req(make_op(MODE_CREATE, 1, 1, 0));
      send_req(make_op(MODE_SUSPEND, 1, 0, 0));
      send_req(make_op(MODE_TICK, 0, 0, 0));              // suspended slot hits zero
      send_req(make_op(MODE_RESUME, 1, 0, 0));
      send_req(make_op(MODE_DELETE, MAX_TASKS - 1, 0, 0));
      send_req(make_op(MODE_TICK, 0, 0, 0));
   endtask

   task automatic test_full_table();
      int i;
      for (i = 0; i < MAX_TASKS; i++)
         send_req(make_op(MODE_CREATE, i, 1, 0));
      send_req(make_op(MODE_TICK, 0, 0, 0));              // every slot fires
   endtask

   function automatic req_type rand_sched_op();
      req_type r;
      int      roll;
      roll            = $urandom_range(99);
      r.task_index    = 8'($urandom_range(MAX_TASKS - 1));
      r.period        = 16'($urandom_range(6, 1));
      r.initial_delay = 8'($urandom_range(3));
      if (roll < 40) begin
         r.mode = MODE_TICK;
      end else if (roll < 65) begin
         r.mode = MODE_CREATE;
         if ($urandom_range(7) == 0) begin
            r.period        = 16'($urandom_range(65535, 1));
            r.initial_delay = 8'($urandom_range(255));
         end
      end else if (roll < 75) begin
         r.mode = MODE_SUSPEND;
      end else if (roll < 82) begin
         r.mode = MODE_RESUME;
      end else if (roll < 88) begin
         r.mode = MODE_DELETE;
      end else begin
         r.mode          = 3'($urandom_range(7));
         r.task_index    = 8'($urandom_range(255));
         r.period        = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535));
         r.initial_delay = 8'($urandom_range(255));
      end
      return r;
   endfunction

   task automatic test_random_mix(input int count, input int idle_pct);
      int n;
      sender_idle_pct = idle_pct;
      for (n = 0; n < count; n++)
         send_req(rand_sched_op());
      wait_drained();
   endtask

   initial begin
      int i;
      for (i = 0; i < MAX_TASKS; i++) begin
         slot_count[i]  = '0;
         slot_reload[i] = '0;
         slot_hold[i]   = 1'b0;
         slot_live[i]   = 1'b0;
      end
      reset <= 1'b1;
      start <= 1'b0;
      req   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 6;
      test_table_errors();
      test_full_table();
      wait_drained();

      test_random_mix(70, 6);
      test_random_mix(70, 80);
      test_random_mix(60, 0);

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire
